// ===== rtl/point_cloud_sector_min_range_defines.svh =====
// Assertion macros for the checker file of the sector minimum range block.
// Needs a clk and an active low rst_n in the scope where the macros are used.
`ifndef POINT_CLOUD_SECTOR_MIN_RANGE_DEFINES_SVH
`define POINT_CLOUD_SECTOR_MIN_RANGE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PCSMR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcsmr check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PCSMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcsmr check failed");

`endif

// ===== rtl/pcsmr_pkg.sv =====
// Package for the point cloud sector minimum range block: sizes, register codes,
// payload structs, sequencer states and the CORDIC arctangent table. No dependencies.
package pcsmr_pkg;

  localparam int MAX_POINTS   = 65536;
  localparam int CORDIC_STEPS = 16;
  localparam int HW_COUNT_MAX = 131071;
  localparam int COUNT_CAP_I  = (MAX_POINTS < HW_COUNT_MAX) ? MAX_POINTS : HW_COUNT_MAX;
  localparam logic [16:0] COUNT_CAP = 17'(COUNT_CAP_I);

  // Square root runs one result bit per cycle, 16 bits of root.
  localparam int SQRT_STEPS = 16;
  localparam int ITER_STEPS = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int ITER_W     = $clog2(ITER_STEPS);
  localparam int ATAN_IDX_W = 5;

  // CORDIC vector width (mm * 256 with gain headroom) and Q30 angle width.
  localparam int CW = 27;
  localparam int AW = 34;
  localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;

  // Register reset values.
  localparam logic signed [12:0] MIN_HEIGHT_RST  = -13'sd200;
  localparam logic signed [12:0] MAX_HEIGHT_RST  = 13'sd900;
  localparam logic [14:0]        FRONT_ANGLE_RST = 15'd2867;
  localparam logic [14:0]        SIDE_LOW_RST    = 15'd3686;
  localparam logic [14:0]        SIDE_HIGH_RST   = 15'd12861;

  typedef enum logic [2:0] {
    CFG_MIN_HEIGHT  = 3'd0,
    CFG_MAX_HEIGHT  = 3'd1,
    CFG_FRONT_ANGLE = 3'd2,
    CFG_SIDE_LOW    = 3'd3,
    CFG_SIDE_HIGH   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ITER,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] z_mm;
    logic               point_ok;
    logic               last_point;
  } pcsmr_in_t;

  typedef struct packed {
    logic [15:0] front_range_mm;
    logic [15:0] left_range_mm;
    logic [15:0] right_range_mm;
    logic        front_found;
    logic        left_found;
    logic        right_found;
    logic [16:0] kept_count;
  } pcsmr_out_t;

  // atan(2^-i) in Q30.
  function automatic logic [30:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:    v = 31'd843314857;
      5'd1:    v = 31'd497837829;
      5'd2:    v = 31'd263043837;
      5'd3:    v = 31'd133525159;
      5'd4:    v = 31'd67021687;
      5'd5:    v = 31'd33543516;
      5'd6:    v = 31'd16775851;
      5'd7:    v = 31'd8388437;
      5'd8:    v = 31'd4194283;
      5'd9:    v = 31'd2097149;
      5'd10:   v = 31'd1048576;
      5'd11:   v = 31'd524288;
      5'd12:   v = 31'd262144;
      5'd13:   v = 31'd131072;
      5'd14:   v = 31'd65536;
      5'd15:   v = 31'd32768;
      5'd16:   v = 31'd16384;
      5'd17:   v = 31'd8192;
      5'd18:   v = 31'd4096;
      5'd19:   v = 31'd2048;
      5'd20:   v = 31'd1024;
      5'd21:   v = 31'd512;
      5'd22:   v = 31'd256;
      5'd23:   v = 31'd128;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/point_cloud_sector_min_range.sv =====
// Point cloud sector minimum range: top level, single module.
// Depends on pcsmr_pkg.
//
// Takes one lidar point per input word. A point is kept when point_ok is set
// and min_height_mm <= z_mm <= max_height_mm. A kept point is counted
// (saturating at the count cap) and its planar range (rounded sqrt of
// x*x + y*y) and bearing (CORDIC atan2, Q2.13 radians) are worked out; it then
// lowers the running minimum of the first matching sector: front, left or right.
// A word with last_point set closes the frame: one result word carries the
// three minima (0 when the sector saw nothing), the found flags and the count,
// and the frame state is cleared. Registers keep their values.
// Flow: a dropped point is taken without a stall. A kept point holds the input
// stalled through two passes through the shared 16x16 multiplier for x*x and
// y*y, 16 passes through the iteration unit (one root bit plus one CORDIC
// rotation per cycle), a rounding step and a sector update step. A last point
// then goes through the emit state to load the output register, and waits there
// while the previous result still sits stalled. Input words are taken while
// a result waits downstream. Config writes are only legal while idle.
module point_cloud_sector_min_range
  import pcsmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input point channel
  input  logic        in_valid,
  output logic        in_stall,
  input  pcsmr_in_t   in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output pcsmr_out_t  out_data,
  // register write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic signed [12:0] min_h_r;
  logic signed [12:0] max_h_r;
  logic [14:0]        front_ang_r;
  logic [14:0]        side_lo_r;
  logic [14:0]        side_hi_r;

  // captured point
  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic               zero_r;   // origin point, bearing forced to 0
  logic               last_r;

  // square root: remainder, partial root, current bit
  logic [31:0] rem_r;
  logic [31:0] root_r;
  logic [31:0] bit_r;

  // CORDIC vector and angle accumulator
  logic signed [CW-1:0] cx_r;
  logic signed [CW-1:0] cy_r;
  logic signed [AW-1:0] ang_r;

  logic [ITER_W-1:0] cnt_r;

  logic [15:0]        rng_r;
  logic signed [17:0] bear_r;

  // frame state
  logic [15:0] front_near_r;
  logic [15:0] left_near_r;
  logic [15:0] right_near_r;
  logic [2:0]  hits_r;       // bit0 front, bit1 left, bit2 right
  logic [16:0] kept_r;

  logic       out_valid_r;
  pcsmr_out_t out_r;

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  logic               in_fire;
  logic               kept_in;
  logic signed [15:0] min_h_ext;
  logic signed [15:0] max_h_ext;
  logic               out_free;

  assign min_h_ext = {{3{min_h_r[12]}}, min_h_r};
  assign max_h_ext = {{3{max_h_r[12]}}, max_h_r};
  assign in_fire   = in_valid && !in_stall;
  assign kept_in   = in_data.point_ok &&
                     (in_data.z_mm >= min_h_ext) && (in_data.z_mm <= max_h_ext);
  // output register can take a word this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (kept_in) begin
            state_nxt = ST_SQ_X;
          end else if (in_data.last_point) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SQ_X:  state_nxt = ST_SQ_Y;
      ST_SQ_Y:  state_nxt = ST_ITER;
      ST_ITER: begin
        if (cnt_r == ITER_W'(ITER_STEPS - 1)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: x*x, then y*y accumulated
  // ---------------------------------------------------------------------------
  logic signed [15:0] mul_op;
  logic signed [31:0] mul_p;
  logic [31:0]        sq;

  assign mul_op = (state_r == ST_SQ_Y) ? y_r : x_r;
  assign mul_p  = mul_op * mul_op;
  assign sq     = 32'(unsigned'(mul_p));

  // ---------------------------------------------------------------------------
  // Iteration unit: one root bit and one CORDIC rotation per cycle
  // ---------------------------------------------------------------------------
  logic [32:0]          trial;
  logic                 trial_ok;
  logic signed [CW-1:0] cx_sh;
  logic signed [CW-1:0] cy_sh;
  logic signed [AW-1:0] atan_v;
  logic signed [CW-1:0] x_pre;
  logic signed [CW-1:0] y_pre;

  assign trial    = {1'b0, root_r} + {1'b0, bit_r};
  assign trial_ok = {1'b0, rem_r} >= trial;
  assign cx_sh    = cx_r >>> cnt_r;
  assign cy_sh    = cy_r >>> cnt_r;
  assign atan_v   = signed'({{(AW-31){1'b0}}, atan_q30(ATAN_IDX_W'(cnt_r))});
  // point scaled by 256
  assign x_pre    = {{(CW-24){x_r[15]}}, x_r, 8'd0};
  assign y_pre    = {{(CW-24){y_r[15]}}, y_r, 8'd0};

  // rounding of range and bearing
  logic signed [AW-1:0] ang_rnd;
  logic signed [AW-1:0] ang_sh;

  assign ang_rnd = ang_r + AW'(65536);
  assign ang_sh  = ang_rnd >>> 17;

  // ---------------------------------------------------------------------------
  // Sector classification
  // ---------------------------------------------------------------------------
  logic signed [17:0] abs_bear;
  logic signed [17:0] front_lim;
  logic signed [17:0] side_lo;
  logic signed [17:0] side_hi;
  logic               in_front;
  logic               in_left;
  logic               in_right;

  assign abs_bear  = bear_r[17] ? -bear_r : bear_r;
  assign front_lim = signed'({3'd0, front_ang_r});
  assign side_lo   = signed'({3'd0, side_lo_r});
  assign side_hi   = signed'({3'd0, side_hi_r});
  assign in_front  = abs_bear <= front_lim;
  assign in_left   = (bear_r >= side_lo) && (bear_r <= side_hi);
  assign in_right  = (bear_r <= -side_lo) && (bear_r >= -side_hi);

  // ---------------------------------------------------------------------------
  // Control and frame state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      min_h_r      <= MIN_HEIGHT_RST;
      max_h_r      <= MAX_HEIGHT_RST;
      front_ang_r  <= FRONT_ANGLE_RST;
      side_lo_r    <= SIDE_LOW_RST;
      side_hi_r    <= SIDE_HIGH_RST;
      front_near_r <= '1;
      left_near_r  <= '1;
      right_near_r <= '1;
      hits_r       <= '0;
      kept_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_HEIGHT:  min_h_r     <= signed'(cfg_data[12:0]);
          CFG_MAX_HEIGHT:  max_h_r     <= signed'(cfg_data[12:0]);
          CFG_FRONT_ANGLE: front_ang_r <= cfg_data;
          CFG_SIDE_LOW:    side_lo_r   <= cfg_data;
          CFG_SIDE_HIGH:   side_hi_r   <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == ST_UPDATE) begin
        if (kept_r < COUNT_CAP) begin
          kept_r <= kept_r + 17'd1;
        end
        // first matching sector wins
        if (in_front) begin
          if (rng_r < front_near_r) front_near_r <= rng_r;
          hits_r[0] <= 1'b1;
        end else if (in_left) begin
          if (rng_r < left_near_r) left_near_r <= rng_r;
          hits_r[1] <= 1'b1;
        end else if (in_right) begin
          if (rng_r < right_near_r) right_near_r <= rng_r;
          hits_r[2] <= 1'b1;
        end
      end

      if (state_r == ST_EMIT && out_free) begin
        out_valid_r  <= 1'b1;
        front_near_r <= '1;
        left_near_r  <= '1;
        right_near_r <= '1;
        hits_r       <= '0;
        kept_r       <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath (no reset)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r    <= in_data.x_mm;
      y_r    <= in_data.y_mm;
      zero_r <= (in_data.x_mm == 16'sd0) && (in_data.y_mm == 16'sd0);
      last_r <= in_data.last_point;
    end

    case (state_r)
      ST_SQ_X: begin
        rem_r <= sq;
        // fold left half plane onto the right, angle starts at +/- pi
        if (x_r[15]) begin
          cx_r  <= -x_pre;
          cy_r  <= -y_pre;
          ang_r <= y_r[15] ? -PI_Q30 : PI_Q30;
        end else begin
          cx_r  <= x_pre;
          cy_r  <= y_pre;
          ang_r <= '0;
        end
      end
      ST_SQ_Y: begin
        rem_r  <= rem_r + sq;
        root_r <= '0;
        bit_r  <= 32'h4000_0000;
        cnt_r  <= '0;
      end
      ST_ITER: begin
        cnt_r <= cnt_r + ITER_W'(1);
        if (int'(cnt_r) < SQRT_STEPS) begin
          bit_r <= bit_r >> 2;
          if (trial_ok) begin
            rem_r  <= rem_r - trial[31:0];
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
        end
        if (int'(cnt_r) < CORDIC_STEPS) begin
          if (!cy_r[CW-1]) begin
            cx_r  <= cx_r + cy_sh;
            cy_r  <= cy_r - cx_sh;
            ang_r <= ang_r + atan_v;
          end else begin
            cx_r  <= cx_r - cy_sh;
            cy_r  <= cy_r + cx_sh;
            ang_r <= ang_r - atan_v;
          end
        end
      end
      ST_ROUND: begin
        rng_r  <= root_r[15:0] + 16'(rem_r > root_r);
        bear_r <= zero_r ? 18'sd0 : ang_sh[17:0];
      end
      default: ;
    endcase

    if (state_r == ST_EMIT && out_free) begin
      out_r.front_range_mm <= hits_r[0] ? front_near_r : 16'd0;
      out_r.left_range_mm  <= hits_r[1] ? left_near_r  : 16'd0;
      out_r.right_range_mm <= hits_r[2] ? right_near_r : 16'd0;
      out_r.front_found    <= hits_r[0];
      out_r.left_found     <= hits_r[1];
      out_r.right_found    <= hits_r[2];
      out_r.kept_count     <= kept_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/pcsmr_checker.sv =====
// Port-level checker for the sector minimum range block, bound to its top level.
// Depends on pcsmr_pkg and point_cloud_sector_min_range_defines.svh.
`include "point_cloud_sector_min_range_defines.svh"

module pcsmr_checker
  import pcsmr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input pcsmr_out_t  out_data
);

  // every sector without a hit reports range 0
  logic empty_reads_zero;

  assign empty_reads_zero =
    (out_data.front_found || out_data.front_range_mm == 16'd0) &&
    (out_data.left_found  || out_data.left_range_mm  == 16'd0) &&
    (out_data.right_found || out_data.right_range_mm == 16'd0);

  // a stalled result word holds
  `PCSMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // empty sector reads zero
  `PCSMR_ASSERT_NOW(a_empty_zero, out_valid, empty_reads_zero)

  // count never passes the cap
  `PCSMR_ASSERT_NOW(a_count_cap, out_valid, out_data.kept_count <= COUNT_CAP)

  // a sector hit needs at least one kept point
  `PCSMR_ASSERT_NOW(a_hit_counted, out_valid && (out_data.front_found || out_data.left_found || out_data.right_found), out_data.kept_count != 17'd0)

endmodule

bind point_cloud_sector_min_range pcsmr_checker u_pcsmr_checker (.*);
